/* sv/tagged_decimal_field_parser_defines.svh */
// Assertion macros used by the checker file.
`ifndef TAGGED_DECIMAL_FIELD_PARSER_DEFINES_SVH
`define TAGGED_DECIMAL_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication.
`define TDFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TDFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/tdfp_pkg.sv */
package tdfp_pkg;

   localparam int MAX_CHARS_DEF = 30;

   // parse phases
   localparam logic [2:0] PH_TAG   = 3'd0;
   localparam logic [2:0] PH_SIGN  = 3'd1;
   localparam logic [2:0] PH_FIRST = 3'd2;
   localparam logic [2:0] PH_INT   = 3'd3;
   localparam logic [2:0] PH_FRAC  = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FORMAT   = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // register indexes
   localparam logic REG_EXPECTED_TAG  = 1'b0;
   localparam logic REG_FRACTION_MODE = 1'b1;

   localparam logic [9:0] EXPECTED_TAG_RST = 10'd1;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic [4:0] FRAC_MAX = 5'd31;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] mantissa;
      logic [4:0]         frac_digits;
   } rsp_type;

   typedef struct packed {
      logic    vld;
      req_type item;
   } stage_type;

endpackage

/* sv/tdfp_in_reg.sv */
module tdfp_in_reg
   import tdfp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      go,
   output stage_type stage
);

   logic    vld_ff, vld_in;
   req_type item_ff;

   // slot frees up in the same cycle its item moves on
   assign req_ready = !vld_ff || go;

   always_comb begin
      vld_in = vld_ff;
      if (req_valid && req_ready) begin
         vld_in = 1'b1;
      end else if (go) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign stage.vld  = vld_ff;
   assign stage.item = item_ff;

endmodule

/* sv/tdfp_parse.sv */
module tdfp_parse
   import tdfp_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   input  logic       out_free,
   input  logic [9:0] expected_tag,
   input  logic       fraction_mode,
   output logic       go,
   output logic       rsp_load,
   output rsp_type    rsp_item
);

   logic [2:0]  ph_ff, ph_in;
   logic [9:0]  tag_ff, tag_in;
   logic [1:0]  tag_len_ff, tag_len_in;
   logic        neg_ff, neg_in;
   logic [31:0] value_ff, value_in;
   logic [4:0]  frac_ff, frac_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  err_ff, err_in;
   logic        lz_ff, lz_in;

   logic [7:0]  c;
   logic [3:0]  dval;
   logic        digit, point;
   logic [35:0] sum;
   logic        ovf;
   logic [9:0]  tag_x10;

   assign c     = stage.item.ch;
   assign dval  = c[3:0];
   assign digit = c inside {[CH_ZERO:CH_NINE]};
   assign point = (c == CH_POINT);
   // value * 10 + digit
   assign sum   = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0} + {32'd0, dval};
   assign ovf   = sum > 36'h0_8000_0000;
   // tag * 10, kept to 10 bits
   assign tag_x10 = {tag_ff[6:0], 3'b000} + {tag_ff[8:0], 1'b0};

   assign go = stage.vld && (!stage.item.last || out_free);

   always_comb begin
      ph_in      = ph_ff;
      tag_in     = tag_ff;
      tag_len_in = tag_len_ff;
      neg_in     = neg_ff;
      value_in   = value_ff;
      frac_in    = frac_ff;
      cnt_in     = cnt_ff;
      err_in     = err_ff;
      lz_in      = lz_ff;
      rsp_load   = 1'b0;
      rsp_item   = '0;

      if (go) begin
         if (cnt_ff >= 5'(MAX_CHARS)) begin
            if (err_ff == ST_OK) begin
               err_in = ST_FORMAT;
            end
         end else begin
            cnt_in = cnt_ff + 5'd1;
            if (err_ff == ST_OK) begin
               if (ph_ff == PH_TAG) begin
                  if (c == CH_COLON) begin
                     if (tag_len_ff == 2'd0) begin
                        err_in = ST_FORMAT;
                     end else if (tag_ff != expected_tag) begin
                        err_in = ST_MISMATCH;
                     end else begin
                        ph_in = PH_SIGN;
                     end
                  end else if (!digit || tag_len_ff == 2'd3) begin
                     err_in = ST_FORMAT;
                  end else if (tag_len_ff == 2'd0 && c == CH_ZERO) begin
                     err_in = ST_FORMAT;
                  end else begin
                     tag_in     = tag_x10 + {6'd0, dval};
                     tag_len_in = tag_len_ff + 2'd1;
                  end
               end else if (ph_ff == PH_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
                  neg_in = (c == CH_MINUS);
                  ph_in  = PH_FIRST;
               end else if (!fraction_mode && point) begin
                  err_in = ST_FORMAT;
               end else begin
                  case (ph_ff)
                     PH_SIGN, PH_FIRST: begin
                        if (digit && c != CH_ZERO) begin
                           if (ovf) begin
                              err_in = ST_OVERFLOW;
                           end else begin
                              value_in = sum[31:0];
                           end
                           ph_in = PH_INT;
                        end else if (fraction_mode && c == CH_ZERO) begin
                           lz_in = 1'b1;
                           ph_in = PH_INT;
                        end else if (fraction_mode && point) begin
                           ph_in = PH_FRAC;
                        end else begin
                           err_in = ST_FORMAT;
                        end
                     end
                     PH_INT: begin
                        if (point) begin
                           ph_in = PH_FRAC;
                        end else if (digit && !lz_ff) begin
                           if (ovf) begin
                              err_in = ST_OVERFLOW;
                           end else begin
                              value_in = sum[31:0];
                           end
                        end else begin
                           err_in = ST_FORMAT;
                        end
                     end
                     default: begin
                        if (digit) begin
                           if (ovf) begin
                              err_in = ST_OVERFLOW;
                           end else begin
                              value_in = sum[31:0];
                           end
                           if (frac_ff < FRAC_MAX) begin
                              frac_in = frac_ff + 5'd1;
                           end
                        end else begin
                           err_in = ST_FORMAT;
                        end
                     end
                  endcase
               end
            end
         end

         if (stage.item.last) begin
            if (err_in == ST_OK) begin
               if (ph_in == PH_TAG || ph_in == PH_SIGN || ph_in == PH_FIRST) begin
                  err_in = ST_FORMAT;
               end else if (fraction_mode && ph_in != PH_FRAC) begin
                  err_in = ST_FORMAT;
               end else if (!neg_in && value_in[31]) begin
                  // positive side tops out one below the negative side
                  err_in = ST_OVERFLOW;
               end
            end
            rsp_load        = 1'b1;
            rsp_item.status = err_in;
            if (err_in == ST_OK) begin
               rsp_item.mantissa    = neg_in ? -value_in : value_in;
               rsp_item.frac_digits = frac_in;
            end
            ph_in      = PH_TAG;
            tag_in     = '0;
            tag_len_in = '0;
            neg_in     = 1'b0;
            value_in   = '0;
            frac_in    = '0;
            cnt_in     = '0;
            err_in     = ST_OK;
            lz_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff      <= PH_TAG;
         tag_ff     <= '0;
         tag_len_ff <= '0;
         neg_ff     <= 1'b0;
         value_ff   <= '0;
         frac_ff    <= '0;
         cnt_ff     <= '0;
         err_ff     <= ST_OK;
         lz_ff      <= 1'b0;
      end else begin
         ph_ff      <= ph_in;
         tag_ff     <= tag_in;
         tag_len_ff <= tag_len_in;
         neg_ff     <= neg_in;
         value_ff   <= value_in;
         frac_ff    <= frac_in;
         cnt_ff     <= cnt_in;
         err_ff     <= err_in;
         lz_ff      <= lz_in;
      end
   end

endmodule

/* sv/tdfp_out_reg.sv */
module tdfp_out_reg
   import tdfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type item,
   output logic    out_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign out_free = !vld_ff || rsp_ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= item;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

/* sv/tagged_decimal_field_parser.sv */
// Parses strings of the form TAG ':' [sign] NUMBER, one character per item.
// req channel: one character with a last flag; a result follows only the last one.
// rsp channel: status, signed mantissa and count of digits after the point.
// csr channel: index 0 expected tag, index 1 fraction mode; always ready, write
// only while no string is in flight.
// A character is registered in the input register on acceptance and parsed from
// there; its result is registered in the result register, which drives rsp_valid.
// Throughput: one character per cycle while no last character waits, set by the
// single parse stage (multiply by ten, add and overflow compare between the input and result registers).
// When the receiver stalls, characters that are not last keep flowing; a last
// character waits in the input register until the result register frees up,
// and req_ready drops only then.
// Reset: synchronous; empties both registers, clears the parse state, sets the
// expected tag to 1 and integer mode.
module tagged_decimal_field_parser
   import tdfp_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);

   logic [9:0] expected_tag_ff, expected_tag_in;
   logic       fraction_mode_ff, fraction_mode_in;
   stage_type  stage;
   logic       go, out_free, rsp_load;
   rsp_type    rsp_item;

   assign csr_ready = 1'b1;

   always_comb begin
      expected_tag_in  = expected_tag_ff;
      fraction_mode_in = fraction_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_EXPECTED_TAG:  expected_tag_in  = csr_wdata;
            REG_FRACTION_MODE: fraction_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_tag_ff  <= EXPECTED_TAG_RST;
         fraction_mode_ff <= 1'b0;
      end else begin
         expected_tag_ff  <= expected_tag_in;
         fraction_mode_ff <= fraction_mode_in;
      end
   end

   tdfp_in_reg u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .go        (go),
      .stage     (stage)
   );

   tdfp_parse #(
      .MAX_CHARS (MAX_CHARS)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .out_free      (out_free),
      .expected_tag  (expected_tag_ff),
      .fraction_mode (fraction_mode_ff),
      .go            (go),
      .rsp_load      (rsp_load),
      .rsp_item      (rsp_item)
   );

   tdfp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .item      (rsp_item),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/tdfp_checker.sv */
`include "tagged_decimal_field_parser_defines.svh"

module tdfp_checker
   import tdfp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `TDFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result item dropped or changed while stalled")

   `TDFP_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.mantissa == 32'sd0 && rsp_data.frac_digits == 5'd0, "error result carries a value")

   // input side only backs up behind a held result
   `TDFP_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled with free result register")

   `TDFP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "block not empty after reset")

endmodule

bind tagged_decimal_field_parser tdfp_checker u_tdfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/testbench.sv */
module testbench
   import tdfp_pkg::*;
();

   typedef logic [7:0] text_type[$];

   typedef struct packed {
      logic    known;
      rsp_type want;
   } typed_entry_type;

   typedef struct {
      logic [9:0] tag;
      logic       fmode;
      string      text;
      bit         typed;
      rsp_type    want;
   } drill_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = REG_EXPECTED_TAG;
   logic [9:0] csr_wdata = '0;

   tagged_decimal_field_parser dut (.*);

   // parser shadow: configuration and per-string state
   logic [9:0]  cfg_tag = EXPECTED_TAG_RST;
   logic        cfg_frac = 1'b0;
   logic [2:0]  p_phase;
   logic [9:0]  p_tag;
   logic [1:0]  p_taglen;
   logic        p_neg;
   logic [31:0] p_val;
   logic [4:0]  p_frac;
   logic [4:0]  p_count;
   logic [1:0]  p_err;
   logic        p_lz;

   rsp_type         awaited_results[$];
   typed_entry_type typed_results[$];
   drill_row_type   drill_rows[$];

   int  mismatch_count = 0;
   int  chars_sent = 0;
   int  reg_writes = 0;
   int  status_seen[4] = '{default: 0};
   bit  hold_rsp = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout: parser stopped making progress");
      $display("tagged_decimal_field_parser verification failed");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   function automatic void clear_parse();
      p_phase = PH_TAG;
      p_tag = '0;
      p_taglen = '0;
      p_neg = 1'b0;
      p_val = '0;
      p_frac = '0;
      p_count = '0;
      p_err = ST_OK;
      p_lz = 1'b0;
   endfunction

   function automatic void flag(input logic [1:0] code);
      if (p_err == ST_OK) p_err = code;
   endfunction

   function automatic bit is_decimal(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void push_digit(input logic [7:0] c);
      longint unsigned v;
      v = 64'(p_val) * 64'd10 + 64'(c - CH_ZERO);
      if (v > 64'h8000_0000) flag(ST_OVERFLOW);
      else p_val = v[31:0];
   endfunction

   function automatic void take_tag(input logic [7:0] c);
      if (c == CH_COLON) begin
         if (p_taglen == 0) flag(ST_FORMAT);
         else if (p_tag != cfg_tag) flag(ST_MISMATCH);
         else p_phase = PH_SIGN;
      end else if (!is_decimal(c) || p_taglen >= 3) begin
         flag(ST_FORMAT);
      end else if (p_taglen == 0 && c == CH_ZERO) begin
         flag(ST_FORMAT);
      end else begin
         p_tag = 10'(p_tag * 10 + (c - CH_ZERO));
         p_taglen++;
      end
   endfunction

   function automatic void take_body(input logic [7:0] c);
      bit digit;
      bit point;
      digit = is_decimal(c);
      point = (c == CH_POINT);
      if (p_phase == PH_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
         p_neg = (c == CH_MINUS);
         p_phase = PH_FIRST;
      end else if (!cfg_frac && point) begin
         flag(ST_FORMAT);
      end else begin
         case (p_phase)
            PH_SIGN, PH_FIRST: begin
               if (digit && c != CH_ZERO) begin
                  push_digit(c);
                  p_phase = PH_INT;
               end else if (cfg_frac && c == CH_ZERO) begin
                  p_lz = 1'b1;
                  p_phase = PH_INT;
               end else if (cfg_frac && point) begin
                  p_phase = PH_FRAC;
               end else begin
                  flag(ST_FORMAT);
               end
            end
            PH_INT: begin
               if (point) p_phase = PH_FRAC;
               else if (digit && !p_lz) push_digit(c);
               else flag(ST_FORMAT);
            end
            default: begin
               if (digit) begin
                  push_digit(c);
                  if (p_frac < FRAC_MAX) p_frac++;
               end else begin
                  flag(ST_FORMAT);
               end
            end
         endcase
      end
   endfunction

   // one character through the shadow parser; returns 1 when a result is due
   function automatic bit parse_char(input logic [7:0] c, input logic last,
                                     output rsp_type r);
      r = '0;
      if (p_count >= MAX_CHARS_DEF) begin
         flag(ST_FORMAT);
      end else begin
         p_count++;
         if (p_err == ST_OK) begin
            if (p_phase == PH_TAG) take_tag(c);
            else take_body(c);
         end
      end
      if (!last) return 1'b0;
      if (p_err == ST_OK) begin
         if (p_phase == PH_TAG || p_phase == PH_SIGN || p_phase == PH_FIRST)
            flag(ST_FORMAT);
         else if (cfg_frac && p_phase != PH_FRAC)
            flag(ST_FORMAT);
         else if (!p_neg && p_val > 32'h7FFF_FFFF)
            flag(ST_OVERFLOW);
      end
      r.status = p_err;
      if (p_err == ST_OK) begin
         r.mantissa = p_neg ? (32'd0 - p_val) : p_val;
         r.frac_digits = p_frac;
      end
      clear_parse();
      return 1'b1;
   endfunction

   initial clear_parse();

   always @(posedge clock) begin : watch
      rsp_type         predicted;
      rsp_type         want;
      typed_entry_type lead;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (parse_char(req_data.ch, req_data.last, predicted)) begin
               lead = '0;
               if (typed_results.size() != 0) lead = typed_results.pop_front();
               awaited_results.push_back(lead.known ? lead.want : predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               note_mismatch($sformatf("result with nothing awaited, status %0d",
                                       rsp_data.status));
            end else begin
               want = awaited_results.pop_front();
               status_seen[want.status]++;
               if (rsp_data.status !== want.status)
                  note_mismatch($sformatf("status %0d, want %0d",
                                          rsp_data.status, want.status));
               if (rsp_data.mantissa !== want.mantissa)
                  note_mismatch($sformatf("mantissa %0d, want %0d",
                                          rsp_data.mantissa, want.mantissa));
               if (rsp_data.frac_digits !== want.frac_digits)
                  note_mismatch($sformatf("frac_digits %0d, want %0d",
                                          rsp_data.frac_digits, want.frac_digits));
            end
         end
      end
   end

   // result side: short stalls, steady stretches, a few long stalls, and
   // one long hold-off on request
   initial begin : rsp_pacing
      int unsigned r;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            rsp_ready <= (r < 45);
            if (r < 45) repeat ($urandom_range(1, 40)) @(posedge clock);
            else if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clock);
            else repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_text(input text_type s, input bit typed, input rsp_type want);
      bit          steady;
      int unsigned gap;
      steady = ($urandom_range(0, 3) == 0);
      typed_results.push_back('{known: typed, want: want});
      foreach (s[i]) begin
         gap = steady ? 0 : pick_gap();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= '{ch: s[i], last: (i == s.size() - 1)};
         do @(posedge clock); while (!req_ready);
         chars_sent++;
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [9:0] tag, input logic mode);
      csr_valid <= 1'b1;
      csr_index <= REG_EXPECTED_TAG;
      csr_wdata <= tag;
      do @(posedge clock); while (!csr_ready);
      cfg_tag = tag;
      csr_index <= REG_FRACTION_MODE;
      csr_wdata <= {9'($urandom), mode};
      do @(posedge clock); while (!csr_ready);
      cfg_frac = mode;
      csr_valid <= 1'b0;
      reg_writes += 2;
   endtask

   // string switch between settings: idle first, let the parse stage settle
   task automatic reconfigure(input logic [9:0] tag, input logic mode);
      wait_results_drained();
      repeat (4) @(posedge clock);
      set_config(tag, mode);
   endtask

   function automatic void add_row(input logic [9:0] tag, input logic mode,
                                   input string text, input bit typed,
                                   input logic [1:0] st, input logic [31:0] mant,
                                   input logic [4:0] fd);
      drill_row_type row;
      row.tag = tag;
      row.fmode = mode;
      row.text = text;
      row.typed = typed;
      row.want.status = st;
      row.want.mantissa = mant;
      row.want.frac_digits = fd;
      drill_rows.push_back(row);
   endfunction

   function automatic logic [7:0] rand_digit(input bit nonzero);
      return CH_ZERO + 8'($urandom_range(nonzero ? 1 : 0, 9));
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 7))
         0: return CH_COLON;
         1: return CH_POINT;
         2: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
         3: return rand_digit(1'b0);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void append_decimal(ref text_type s, input longint unsigned v);
      string t;
      t = $sformatf("%0d", v);
      for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
   endfunction

   function automatic text_type well_formed();
      text_type        s;
      text_type        d;
      int unsigned     tag;
      int unsigned     n;
      int unsigned     k;
      int unsigned     r;
      tag = cfg_tag;
      if ($urandom_range(0, 9) < 2 || tag == 0 || tag > 999) tag = $urandom_range(1, 999);
      append_decimal(s, tag);
      s.push_back(CH_COLON);
      case ($urandom_range(0, 2))
         1: s.push_back(CH_PLUS);
         2: s.push_back(CH_MINUS);
         default: ;
      endcase
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // around the 32-bit limit
         append_decimal(d, 64'd2147483646 + $urandom_range(0, 3));
         if (cfg_frac) begin
            k = $urandom_range(1, 10);
            if (k == d.size()) d.push_back(CH_POINT);
            else d.insert(k, CH_POINT);
         end
         s = {s, d};
      end else if (!cfg_frac) begin
         n = (r < 25) ? $urandom_range(10, 11) : $urandom_range(1, 9);
         s.push_back(rand_digit(1'b1));
         repeat (n - 1) s.push_back(rand_digit(1'b0));
      end else begin
         k = $urandom_range(0, 99);
         if (k < 20) s.push_back(CH_ZERO);
         else if (k >= 45) begin
            s.push_back(rand_digit(1'b1));
            repeat ($urandom_range(0, 5)) s.push_back(rand_digit(1'b0));
         end
         s.push_back(CH_POINT);
         k = $urandom_range(0, 9);
         if (k < 8) begin
            repeat ($urandom_range(0, 6)) s.push_back(rand_digit(1'b0));
         end else if (k < 9) begin
            repeat ($urandom_range(7, 12)) s.push_back(rand_digit(1'b0));
         end else begin
            // long zero tail runs into the length limit
            repeat ($urandom_range(15, 28))
               s.push_back($urandom_range(0, 4) ? CH_ZERO : rand_digit(1'b0));
         end
      end
      return s;
   endfunction

   function automatic text_type random_text();
      text_type    s;
      int unsigned r;
      int unsigned pos;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         s = well_formed();
      end else if (r < 88) begin
         s = well_formed();
         pos = $urandom_range(0, s.size() - 1);
         case ($urandom_range(0, 3))
            0: s[pos] = 8'($urandom_range(0, 255));
            1: s[pos] = pick_char();
            2: s.insert(pos, pick_char());
            default: if (pos > 0) s = s[0:pos-1];
         endcase
      end else begin
         repeat ($urandom_range(1, 36)) s.push_back(pick_char());
      end
      return s;
   endfunction

   initial begin : stimulus
      text_type    s;
      logic [9:0]  tag;
      logic        mode;
      int          budget;
      int          phase_chars;

      add_row(10'd1, 1'b0, "1:5", 1'b1, ST_OK, 32'd5, 5'd0);
      add_row(10'd1, 1'b0, "1:-2147483648", 1'b1, ST_OK, 32'h8000_0000, 5'd0);
      add_row(10'd1, 1'b0, "1:2147483647", 1'b1, ST_OK, 32'h7FFF_FFFF, 5'd0);
      add_row(10'd1, 1'b0, "1:2147483648", 1'b1, ST_OVERFLOW, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:99999999999", 1'b1, ST_OVERFLOW, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:0", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:1.5", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "2:7", 1'b1, ST_MISMATCH, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "01:7", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, ":5", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1234:5", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:+-3", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:+40", 1'b0, ST_OK, 32'd0, 5'd0);
      add_row(10'd1, 1'b0, "1:12a9", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd999, 1'b1, "999:3.14", 1'b1, ST_OK, 32'd314, 5'd2);
      add_row(10'd999, 1'b1, "999:-0.0", 1'b1, ST_OK, 32'd0, 5'd1);
      add_row(10'd999, 1'b1, "999:.", 1'b1, ST_OK, 32'd0, 5'd0);
      add_row(10'd999, 1'b1, "999:-.5", 1'b1, ST_OK, -32'sd5, 5'd1);
      add_row(10'd999, 1'b1, "999:00.5", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd999, 1'b1, "999:12", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd999, 1'b1, "999:1.2.3", 1'b1, ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd999, 1'b1, "999:21474836.49", 1'b0, ST_OK, 32'd0, 5'd0);
      // exactly at the character limit, then one past it
      add_row(10'd1, 1'b1, {"1:.", "0000000000", "0000000000", "0000000"}, 1'b0,
              ST_OK, 32'd0, 5'd0);
      add_row(10'd1, 1'b1, {"1:.", "0000000000", "0000000000", "00000000"}, 1'b1,
              ST_FORMAT, 32'd0, 5'd0);
      add_row(10'd0, 1'b1, "1:1.0", 1'b1, ST_MISMATCH, 32'd0, 5'd0);
      add_row(10'd1023, 1'b0, "999:5", 1'b1, ST_MISMATCH, 32'd0, 5'd0);

      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // first rows run on the settings left by reset
      foreach (drill_rows[i]) begin
         if (drill_rows[i].tag != cfg_tag || drill_rows[i].fmode != cfg_frac)
            reconfigure(drill_rows[i].tag, drill_rows[i].fmode);
         s = {};
         for (int j = 0; j < drill_rows[i].text.len(); j++)
            s.push_back(drill_rows[i].text[j]);
         send_text(s, drill_rows[i].typed, drill_rows[i].want);
      end

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin tag = 10'd999; mode = 1'b1; budget = 170; end
            1: begin tag = 10'd1; mode = 1'b0; budget = 170; end
            2: begin tag = 10'($urandom_range(1, 999)); mode = 1'b0; budget = 160; end
            3: begin tag = 10'($urandom_range(1, 999)); mode = 1'b1; budget = 170; end
            4: begin tag = 10'd0; mode = 1'b1; budget = 30; end
            5: begin tag = 10'($urandom_range(1000, 1023)); mode = 1'b0; budget = 30; end
            default: begin
               tag = 10'($urandom_range(1, 999));
               mode = 1'($urandom_range(0, 1));
               budget = 200;
            end
         endcase
         reconfigure(tag, mode);
         // back up the result side while characters keep coming
         if (ph == 2) hold_rsp = 1'b1;
         phase_chars = 0;
         while (phase_chars < budget) begin
            s = random_text();
            send_text(s, 1'b0, '0);
            phase_chars += s.size();
         end
      end

      wait_results_drained();
      repeat (8) @(posedge clock);

      $display("run: %0d characters, %0d register writes over integer and fraction modes",
               chars_sent, reg_writes);
      $display("results: %0d ok, %0d format, %0d tag mismatch, %0d overflow",
               status_seen[ST_OK], status_seen[ST_FORMAT], status_seen[ST_MISMATCH],
               status_seen[ST_OVERFLOW]);
      if (mismatch_count == 0)
         $display("tagged_decimal_field_parser verification clean");
      else
         $display("tagged_decimal_field_parser verification failed");
      $finish;
   end

endmodule
